// ----- hdl/rcfr_pkg.sv -----
`timescale 1ns / 1ps

package rcfr_pkg;

  localparam int NLET   = 26;
  localparam int NSLOT  = 5;
  localparam int NTURN  = 9;
  localparam int NROW   = 32;
  localparam int NCELL  = 2 * NSLOT;

  typedef logic [NSLOT-1:0][4:0] pos_t;

  typedef struct packed {
    logic [4:0] letter;
    pos_t       pos;
  } beat_t;

  typedef enum logic [2:0] {
    REG_ROTOR_LEFT   = 3'd0,
    REG_ROTOR_MIDDLE = 3'd1,
    REG_ROTOR_RIGHT  = 3'd2,
    REG_STATOR_FIRST = 3'd3,
    REG_STATOR_ENTRY = 3'd4,
    REG_START_POS    = 3'd5
  } reg_idx_e;

  // Rows 0..15 forward wirings, rows 16..31 their inverses.
  localparam logic [8*NLET-1:0] WIRING [NROW] = '{
    "QWECYJIBFKMLTVZPOHUDGNRSXA", "AJDKSIRUXBLHWTMCQGZNPYFVOE",
    "BDFHJLCPRTXVZNYEIWGAKMUSQO", "ESOVPZJAYQUIRHXLNFTGKDCMWB",
    "VZBRGITYUPSDNHLXAWMJQOFECK", "FVPJIAOYEDRZXWGCTKUQSBNMHL",
    "KZGLIUCJEHADXRYWVTNSFQPMOB", "ZLVGOIFTYWUEPMABNCXRQSDKHJ",
    "QAXSRNGDUHOPZVTLMKFBIJYCEW", "AEOVFYPNZGQCMTWHLBXURISKDJ",
    "BOQSUMKAGWIEYNZVXTRPCLJHFD", "EBWMCDKGTFNLXHRIUQYAJZPVOS",
    "VKCEFOQJMWAXLHNDSPUYTIGRBZ", "FLHMNBSQUKTCGWXZRDEYOAIJPV",
    "KBOMPQFSNTVWYRXDAHEJCUILGZ", "ZJHKDSQRXCNBAMPEUWYTFIOGVL",
    "ZHDTCIURGFJLKVQPAWXMSNBYEO", "AJPCZWRLFBDKOTYUQGENHXMIVS",
    "TAGBPCSDQEUFVNZHYIXJWLRKOM", "HZWVARTNLGUPXQCEJMBSKDYOIF",
    "QCYLXWENFTZOSMVJUDKGIARPHB", "FVPJIAOYEDRZXWGCTKUQSBNMHL",
    "KZGLIUCJEHADXSYWVNTRFQPMOB", "OPRWLGDYFZXBNQEMUTVHKCJSIA",
    "BTXHYSGJUVRPQFKLAEDOINZCWM", "ARLYBEJPVZXQMHCGKUWNTDOSFI",
    "HAUZLYIXKWGVFNBTCSDREPJQMO", "TBEFAJHNPUGLDKYWROZIQXCMSV",
    "KYCPDEWNVHBMIOFRGXQUSAJLTZ", "VFLRSAMCWXJBDEUYHQGKIZNOTP",
    "QBUPSGYRWTAXDICEFNHJVKLOMZ", "MLJEPUXCVBDZNKWOGHFTQYRISA"
  };

  localparam logic [8*NLET-1:0] MIRROR = "YRUHQSLDPXNGOKMIEBFZCWVJAT";

  localparam logic [4:0] TURN_AT [NTURN] = '{
    5'd0, 5'd2, 5'd4, 5'd8, 5'd13, 5'd16, 5'd19, 5'd21, 5'd24
  };

  localparam logic [7:0] CHAR_A = 8'd65;

  // Letter at column col of a packed string, first character at the top.
  function automatic logic [4:0] char_at(logic [8*NLET-1:0] str, logic [4:0] col);
    logic [7:0] ch;
    ch = str[8*(NLET-1-int'(col)) +: 8];
    return 5'(ch - CHAR_A);
  endfunction

endpackage

// ----- hdl/rcfr_step.sv -----
`timescale 1ns / 1ps

module rcfr_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  logic                kind_i,
  input  logic [4:0]          letter_i,
  input  logic [24:0]         start_i,
  output logic                valid_o,
  input  logic                stall_i,
  output rcfr_pkg::beat_t     beat_o
);
  import rcfr_pkg::*;

  pos_t       pos_q, pos_d;
  logic       valid_q;
  beat_t      beat_q;
  logic       accept;
  logic [4:0] p0, p1, p2;
  logic [4:0] letter_fold;
  logic [4:0] mid, rgt;
  logic       mid_notch, rgt_notch;
  logic       bonus_eq, bonus_ne;
  logic [1:0] adv0, adv1;

  function automatic logic [4:0] inc26(logic [4:0] v);
    return (v == 5'(NLET - 1)) ? 5'd0 : v + 5'd1;
  endfunction

  function automatic logic [4:0] fold26(logic [4:0] v);
    return (v >= 5'(NLET)) ? v - 5'(NLET) : v;
  endfunction

  function automatic logic [4:0] add26(logic [4:0] v, logic [1:0] a);
    logic [5:0] sum;
    sum = {1'b0, v} + {4'd0, a};
    return (sum >= 6'(NLET)) ? 5'(sum - 6'(NLET)) : sum[4:0];
  endfunction

  function automatic logic is_notch(logic [4:0] v);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NTURN; i++) begin
      hit = hit | (v == TURN_AT[i]);
    end
    return hit;
  endfunction

  assign stall_o = valid_q & stall_i;
  assign accept  = valid_i & ~stall_o;
  assign letter_fold = fold26(letter_i);

  always_comb begin
    mid       = pos_q[1];
    rgt       = pos_q[2];
    mid_notch = is_notch(mid);
    rgt_notch = is_notch(rgt);
    // an extra middle step may carry the middle onto a notch still ahead
    bonus_eq  = is_notch(mid + 5'd2);
    bonus_ne  = is_notch(mid + 5'd1) & (mid > rgt);

    // closed form of the ordered notch scan; later notches see earlier updates
    if (!rgt_notch) begin
      adv0 = {1'b0, mid_notch};
      adv1 = {1'b0, mid_notch};
    end else if (mid == rgt) begin
      adv0 = 2'd1 + {1'b0, bonus_eq};
      adv1 = 2'd2 + {1'b0, bonus_eq};
    end else if (mid_notch && (mid < rgt)) begin
      adv0 = 2'd1;
      adv1 = 2'd2;
    end else begin
      adv0 = {1'b0, bonus_ne};
      adv1 = 2'd1 + {1'b0, bonus_ne};
    end

    p0 = add26(pos_q[0], adv0);
    p1 = add26(mid, adv1);
    p2 = inc26(rgt);

    pos_d = pos_q;
    if (kind_i) begin
      for (int s = 0; s < NSLOT; s++) begin
        pos_d[s] = fold26(start_i[5*s +: 5]);
      end
    end else begin
      pos_d[0] = p0;
      pos_d[1] = p1;
      pos_d[2] = p2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pos_q <= pos_d;
      end
      if (!stall_o) begin
        // restart beats leave no result
        valid_q <= valid_i & ~kind_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o) begin
      beat_q.letter <= letter_fold;
      beat_q.pos    <= pos_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ----- hdl/rcfr_cell.sv -----
`timescale 1ns / 1ps

module rcfr_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  rcfr_pkg::beat_t     beat_i,
  input  logic [4:0]          row_i,
  input  logic [4:0]          off_i,
  output logic                valid_o,
  input  logic                stall_i,
  output rcfr_pkg::beat_t     beat_o
);
  import rcfr_pkg::*;

  logic       valid_q;
  beat_t      beat_q;
  logic [5:0] sum;
  logic [4:0] col;
  logic [4:0] wired;
  logic [4:0] letter_d;

  assign stall_o = valid_q & stall_i;

  always_comb begin
    sum   = {1'b0, beat_i.letter} + {1'b0, off_i};
    col   = (sum >= 6'(NLET)) ? 5'(sum - 6'(NLET)) : sum[4:0];
    wired = char_at(WIRING[row_i], col);
    // shift back by the offset, wrapping below A
    if (wired >= off_i) begin
      letter_d = wired - off_i;
    end else begin
      letter_d = 5'(6'(wired) + 6'(NLET) - 6'(off_i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o) begin
      beat_q.letter <= letter_d;
      beat_q.pos    <= beat_i.pos;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ----- hdl/rotor_cipher_five_rotor_reflector.sv -----
`timescale 1ns / 1ps

// Five-rotor reflecting rotor cipher. A letter beat first steps the left,
// middle and right positions, then runs through a chain of ten rotor cells
// (entry stator to left rotor, reflector, left rotor back to entry stator),
// one cell per cycle. One beat is taken every cycle unless the output is
// stalled; the stepping stage and each of the ten cells register the beat.
// A restart beat reloads the positions from the start position register
// and gives no result. Every stage holds its beat while the output is
// stalled. Registers sit at byte addresses 0, 4, .. 20 on the APB port: the
// five wiring choices (8..15 are reversed rotors) and the packed start
// positions, slot 0 in the low bits; start values above 25 wrap by 26.
module rotor_cipher_five_rotor_reflector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [4:0]  letter_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  cipher_letter_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rcfr_pkg::*;

  logic [NSLOT-1:0][3:0] sel_q;
  logic [24:0]           start_q;
  logic                  wr_en;
  logic [2:0]            reg_idx;

  beat_t            beat  [NCELL+1];
  logic [NCELL:0]   valid;
  logic [NCELL:0]   stall;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q[0] <= 4'd0;
      sel_q[1] <= 4'd1;
      sel_q[2] <= 4'd2;
      sel_q[3] <= 4'd3;
      sel_q[4] <= 4'd4;
      start_q  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ROTOR_LEFT:   sel_q[0] <= pwdata[3:0];
        REG_ROTOR_MIDDLE: sel_q[1] <= pwdata[3:0];
        REG_ROTOR_RIGHT:  sel_q[2] <= pwdata[3:0];
        REG_STATOR_FIRST: sel_q[3] <= pwdata[3:0];
        REG_STATOR_ENTRY: sel_q[4] <= pwdata[3:0];
        REG_START_POS:    start_q  <= pwdata[24:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROTOR_LEFT:   prdata = {28'd0, sel_q[0]};
      REG_ROTOR_MIDDLE: prdata = {28'd0, sel_q[1]};
      REG_ROTOR_RIGHT:  prdata = {28'd0, sel_q[2]};
      REG_STATOR_FIRST: prdata = {28'd0, sel_q[3]};
      REG_STATOR_ENTRY: prdata = {28'd0, sel_q[4]};
      REG_START_POS:    prdata = {7'd0, start_q};
      default:          prdata = '0;
    endcase
  end

  rcfr_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .stall_o  (in_stall_o),
    .kind_i   (kind_i),
    .letter_i (letter_i),
    .start_i  (start_q),
    .valid_o  (valid[0]),
    .stall_i  (stall[0]),
    .beat_o   (beat[0])
  );

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    localparam int SLOT = (k < NSLOT) ? (NSLOT - 1 - k) : (k - NSLOT);
    beat_t      cell_in;
    logic [4:0] row;

    always_comb begin
      cell_in = beat[k];
      // reflect between the inward and outward passes
      if (k == NSLOT) begin
        cell_in.letter = char_at(MIRROR, beat[k].letter);
      end
    end

    assign row = {(k >= NSLOT) ? 1'b1 : 1'b0, sel_q[SLOT]};

    rcfr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[k]),
      .stall_o (stall[k]),
      .beat_i  (cell_in),
      .row_i   (row),
      .off_i   (beat[k].pos[SLOT]),
      .valid_o (valid[k+1]),
      .stall_i (stall[k+1]),
      .beat_o  (beat[k+1])
    );
  end

  assign stall[NCELL]    = out_stall_i;
  assign out_valid_o     = valid[NCELL];
  assign cipher_letter_o = beat[NCELL].letter;

endmodule
